// ===== design/vau_pkg.sv =====
`default_nettype none

package vau_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Number of steps of the square root pipeline (two radicand bits per step).
  localparam int unsigned SQRT_STAGES = 32;

  typedef enum logic [2:0] {
    CMD_ADD       = 3'd0,
    CMD_SUB       = 3'd1,
    CMD_SCALE     = 3'd2,
    CMD_DIVIDE    = 3'd3,
    CMD_CROSS     = 3'd4,
    CMD_DOT       = 3'd5,
    CMD_NORMALIZE = 3'd6,
    CMD_LENGTH    = 3'd7
  } cmd_e;

  // A 32-bit component together with its clamp flag.
  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat_t;

  localparam logic signed [65:0] MAX32_W = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] MIN32_W = -66'sh0_8000_0000;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > MAX32_W) begin
      r.val = 32'sh7FFF_FFFF;
      r.sat = 1'b1;
    end else if (v < MIN32_W) begin
      r.val = 32'sh8000_0000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/vau_lane.sv =====
`default_nettype none

module vau_lane #(
  parameter int unsigned FRACTION_BITS = vau_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire vau_pkg::cmd_e       cmd_i,
  input  wire logic signed [31:0]  a_i,
  input  wire logic signed [31:0]  b_i,
  input  wire logic signed [31:0]  s_i,
  input  wire logic signed [31:0]  aj_i,
  input  wire logic signed [31:0]  bj_i,
  input  wire logic signed [31:0]  ak_i,
  input  wire logic signed [31:0]  bk_i,
  output vau_pkg::sat_t            res_o,
  output logic signed [63:0]       term_o
);
  import vau_pkg::*;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] m1_q, m2_q;
  logic signed [32:0] addsub_q;
  cmd_e               cmd1_q;
  logic signed [64:0] diff;
  sat_t               res_d, res_q;
  logic signed [63:0] term_q;

  // The first multiplier is shared between all operations that need a product; the cross product also uses the second.
  always_comb begin
    case (cmd_i)
      CMD_SCALE: begin
        op_a = a_i;
        op_b = s_i;
      end
      CMD_CROSS: begin
        op_a = aj_i;
        op_b = bk_i;
      end
      CMD_NORMALIZE, CMD_LENGTH: begin
        op_a = a_i;
        op_b = a_i;
      end
      default: begin
        op_a = a_i;
        op_b = b_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q     <= op_a * op_b;
      m2_q     <= ak_i * bj_i;
      addsub_q <= (cmd_i == CMD_SUB) ? (33'(a_i) - 33'(b_i)) : (33'(a_i) + 33'(b_i));
      cmd1_q   <= cmd_i;
    end
  end

  assign diff = 65'(m1_q) - 65'(m2_q);

  always_comb begin
    case (cmd1_q)
      CMD_ADD, CMD_SUB: res_d = sat32(66'(addsub_q));
      CMD_SCALE:        res_d = sat32(66'(m1_q >>> FRACTION_BITS));
      CMD_CROSS:        res_d = sat32(66'(diff >>> FRACTION_BITS));
      default:          res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      term_q <= m1_q;
    end
  end

  assign res_o  = res_q;
  assign term_o = term_q;

endmodule

`default_nettype wire

// ===== design/vau_sqrt.sv =====
`default_nettype none

module vau_sqrt (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] rad_i,
  output logic      [31:0] root_o
);
  import vau_pkg::*;

  logic [63:0] n_q [SQRT_STAGES];
  logic [63:0] r_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] n_in, r_in, trial;

    if (k == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_in >= trial) begin
          n_q[k] <= n_in - trial;
          r_q[k] <= (r_in >> 1) + BIT;
        end else begin
          n_q[k] <= n_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  // The root of a 64-bit radicand below 2^64 fits in 32 bits.
  assign root_o = r_q[SQRT_STAGES-1][31:0];

endmodule

`default_nettype wire

// ===== design/vau_div.sv =====
`default_nettype none

module vau_div #(
  parameter int unsigned FRACTION_BITS = vau_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [32+FRACTION_BITS-1:0] dvd_i,
  input  wire logic [31:0]                 dsr_i,
  output logic      [32+FRACTION_BITS-1:0] quo_o
);
  localparam int unsigned QW = 32 + FRACTION_BITS;

  logic [31:0]   rem_q [QW];
  logic [31:0]   dsr_q [QW];
  logic [QW-1:0] dvd_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [31:0]   rem_in, dsr_in;
    logic [QW-1:0] dvd_in, quo_in;
    logic [32:0]   cand;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dsr_in = dsr_i;
      assign dvd_in = dvd_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dsr_in = dsr_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign cand = {rem_in, dvd_in[QW-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dsr_q[k] <= dsr_in;
        dvd_q[k] <= {dvd_in[QW-2:0], 1'b0};
        if (cand >= {1'b0, dsr_in}) begin
          rem_q[k] <= 32'(cand - {1'b0, dsr_in});
          quo_q[k] <= {quo_in[QW-2:0], 1'b1};
        end else begin
          rem_q[k] <= cand[31:0];
          quo_q[k] <= {quo_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

`default_nettype wire

// ===== design/vector3_arithmetic_unit_core.sv =====
// From an accepted input transaction to its result, data passes two lane stages,
// one merge stage, 32 square root steps, 32 + FRACTION_BITS divider steps and the
// output register.
// Throughput: one transaction per cycle; the whole pipeline advances whenever the
// output register is empty or is being taken. Reset clears every valid bit at once.
`default_nettype none

module vector3_arithmetic_unit_core #(
  parameter int unsigned FRACTION_BITS = vau_pkg::FRACTION_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input stream.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0 up: a_x, a_y, a_z, b_x, b_y, b_z, scale_factor (32 bits each).
  input  wire logic [223:0] s_axis_tdata,
  // tuser: command.
  input  wire logic [2:0]   s_axis_tuser,
  // Result stream.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata from bit 0 up: out_x, out_y, out_z, scalar_out (32 bits each).
  output logic [127:0]      m_axis_tdata,
  // tuser from bit 0 up: zero_divisor, saturated.
  output logic [1:0]        m_axis_tuser
);
  import vau_pkg::*;

  localparam int unsigned QW = 32 + FRACTION_BITS;
  localparam int unsigned DL = SQRT_STAGES + QW;

  // Fields that travel alongside the square root and the dividers.
  typedef struct packed {
    cmd_e                     cmd;
    logic signed [2:0][31:0]  a;
    logic signed [31:0]       s;
    logic signed [2:0][31:0]  vec;
    logic                     vsat;
    logic signed [65:0]       dot;
  } carry_t;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [2:0][31:0]  a;
    logic signed [31:0]       s;
  } head_t;

  // The pipeline moves as one whenever the output register can take a new result.
  logic en;
  logic acc;
  logic m_valid_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && en;
  assign s_axis_tready = en;

  logic signed [31:0] a_in [3];
  logic signed [31:0] b_in [3];
  logic signed [31:0] s_in;
  cmd_e               cmd_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_in[i] = s_axis_tdata[32*i +: 32];
      b_in[i] = s_axis_tdata[96 + 32*i +: 32];
    end
    s_in   = s_axis_tdata[192 +: 32];
    cmd_in = cmd_e'(s_axis_tuser);
  end

  // Three lanes, one per component; the cross product borrows the other two.
  sat_t               lane_res  [3];
  logic signed [63:0] lane_term [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vau_lane #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .cmd_i (cmd_in),
      .a_i   (a_in[i]),
      .b_i   (b_in[i]),
      .s_i   (s_in),
      .aj_i  (a_in[(i+1)%3]),
      .bj_i  (b_in[(i+1)%3]),
      .ak_i  (a_in[(i+2)%3]),
      .bk_i  (b_in[(i+2)%3]),
      .res_o (lane_res[i]),
      .term_o(lane_term[i])
    );
  end

  // Copy of the operands that keeps step with the two lane stages.
  head_t head_d, head1_q, head2_q;
  logic  v1_q, v2_q, v3_q;

  always_comb begin
    head_d.cmd = cmd_in;
    for (int i = 0; i < 3; i++) begin
      head_d.a[i] = a_in[i];
    end
    head_d.s = s_in;
  end

  // Merging stage: the exact sum of the dot product is formed, to be floored once later,
  // and the sum of squares feeds the square root.
  carry_t      st3_d, st3_q;
  logic [63:0] sumsq_d, sumsq_q;

  always_comb begin
    st3_d.cmd  = head2_q.cmd;
    st3_d.a    = head2_q.a;
    st3_d.s    = head2_q.s;
    st3_d.vsat = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
    for (int i = 0; i < 3; i++) begin
      st3_d.vec[i] = lane_res[i].val;
    end
    st3_d.dot = 66'(lane_term[0]) + 66'(lane_term[1]) + 66'(lane_term[2]);
    sumsq_d   = lane_term[0] + lane_term[1] + lane_term[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      head1_q <= head_d;
      head2_q <= head1_q;
      st3_q   <= st3_d;
      sumsq_q <= sumsq_d;
    end
  end

  // Square root of the sum of squares.
  logic [31:0] root;

  vau_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (sumsq_q),
    .root_o(root)
  );

  // Delay line beside the square root and the dividers.
  carry_t      dl_q   [DL];
  logic        dlv_q  [DL];
  logic [31:0] root_q [QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0]   <= st3_q;
      root_q[0] <= root;
      for (int k = 1; k < DL; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
      for (int k = 1; k < QW; k++) begin
        root_q[k] <= root_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int k = 0; k < DL; k++) begin
        dlv_q[k] <= 1'b0;
      end
    end else if (en) begin
      v1_q     <= acc;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      dlv_q[0] <= v3_q;
      for (int k = 1; k < DL; k++) begin
        dlv_q[k] <= dlv_q[k-1];
      end
    end
  end

  // Dividers: the magnitude of each component, shifted up by the fraction bits,
  // over the length (normalise) or the magnitude of the scalar (divide).
  carry_t      at_div;
  logic [31:0] dsr;
  logic [31:0] s_mag;

  assign at_div = dl_q[SQRT_STAGES-1];
  assign s_mag  = at_div.s[31] ? 32'(-at_div.s) : at_div.s;
  assign dsr    = (at_div.cmd == CMD_NORMALIZE) ? root : s_mag;

  logic [QW-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [31:0] a_mag;

    assign a_mag = at_div.a[i][31] ? 32'(-at_div.a[i]) : at_div.a[i];

    vau_div #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
      .clk_i(clk_i),
      .en_i (en),
      .dvd_i({a_mag, {FRACTION_BITS{1'b0}}}),
      .dsr_i(dsr),
      .quo_o(quo[i])
    );
  end

  // Final selection: signed quotients truncated toward zero, then clamped.
  carry_t      fin;
  logic [31:0] fin_root;
  sat_t        qres [3];

  assign fin      = dl_q[DL-1];
  assign fin_root = root_q[QW-1];

  for (genvar i = 0; i < 3; i++) begin : g_quo
    logic              neg;
    logic signed [QW:0] qs;

    assign neg  = fin.a[i][31] ^ ((fin.cmd == CMD_DIVIDE) && fin.s[31]);
    assign qs   = neg ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
    assign qres[i] = sat32(66'(qs));
  end

  logic [127:0] tdata_d;
  logic [1:0]   tuser_d;

  always_comb begin
    sat_t dot_res;
    logic zdiv;
    dot_res = sat32(fin.dot >>> FRACTION_BITS);
    zdiv    = 1'b0;
    tdata_d = '0;
    tuser_d = '0;
    case (fin.cmd)
      CMD_DIVIDE, CMD_NORMALIZE: begin
        if (fin.cmd == CMD_DIVIDE) begin
          zdiv = (fin.s == '0);
        end else begin
          zdiv = (fin.a == '0);
        end
        if (!zdiv) begin
          for (int i = 0; i < 3; i++) begin
            tdata_d[32*i +: 32] = qres[i].val;
          end
          tuser_d[1] = qres[0].sat | qres[1].sat | qres[2].sat;
        end
        tuser_d[0] = zdiv;
      end
      CMD_DOT: begin
        tdata_d[96 +: 32] = dot_res.val;
        tuser_d[1]        = dot_res.sat;
      end
      CMD_LENGTH: begin
        // A length of 2^31 or more is clamped to the largest positive value.
        tdata_d[96 +: 32] = fin_root[31] ? 32'h7FFF_FFFF : fin_root;
        tuser_d[1]        = fin_root[31];
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          tdata_d[32*i +: 32] = fin.vec[i];
        end
        tuser_d[1] = fin.vsat;
      end
    endcase
  end

  // Output register.
  logic [127:0] m_tdata_q;
  logic [1:0]   m_tuser_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_tdata_q <= tdata_d;
      m_tuser_q <= tuser_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= dlv_q[DL-1];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== design/vau_checker.sv =====
`default_nettype none

module vau_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [223:0] s_axis_tdata,
  input wire logic [2:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // With the output register empty, the input side is always open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // A zero divisor gives zeros and never a clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && (m_axis_tdata == '0))
    else $error("zero divisor result not cleared");

  // Back-pressure reaches the input side at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline stalled");

endmodule

bind vector3_arithmetic_unit_core vau_checker u_vau_checker (.*);

`default_nettype wire

// ===== sim/vector3_arithmetic_unit_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module vector3_arithmetic_unit_core_tb;
  import vau_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = 68 + FRAC;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam longint MAX_S32 = 64'sd2147483647;
  localparam longint MIN_S32 = -64'sd2147483648;

  // One input transaction: the command and the seven packed operand words.
  typedef struct packed {
    cmd_e         cmd;
    logic [223:0] operands;
  } vec_request_t;

  // One result transaction: four words and the two flags.
  typedef struct packed {
    logic [127:0] words;
    logic [1:0]   flags;
  } vec_result_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [223:0] s_axis_tdata;
  logic [2:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  vec_request_t pending_requests[$];
  vec_result_t  awaited_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  send_gap = 0;
  int unsigned  take_gap = 0;
  bit           sender_hold = 1'b0;
  bit           stimulus_done = 1'b0;

  vector3_arithmetic_unit_core #(.FRACTION_BITS(FRAC)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Clamp to the signed 32-bit range, noting whether clamping happened.
  function automatic longint clamp_word(input longint v, inout bit clipped);
    if (v > MAX_S32) begin
      clipped = 1'b1;
      return MAX_S32;
    end
    if (v < MIN_S32) begin
      clipped = 1'b1;
      return MIN_S32;
    end
    return v;
  endfunction

  // Floor division by two to the fraction bits (arithmetic shift floors already).
  function automatic longint floor_frac(input longint v);
    return v >>> FRAC;
  endfunction

  // Integer square root (floor) of an unsigned 64-bit radicand.
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Compute the single result that the unit must return for a request.
  function automatic vec_result_t vector_outcome(input vec_request_t req);
    longint a[3], b[3], r[3];
    longint s, scalar, hi, lo, p, h;
    longint unsigned len, sq;
    bit clipped, zdiv;
    vec_result_t res;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(req.operands[32*i +: 32]));
      b[i] = longint'($signed(req.operands[32*(i+3) +: 32]));
      r[i] = 0;
    end
    s = longint'($signed(req.operands[192 +: 32]));
    scalar = 0;
    clipped = 1'b0;
    zdiv = 1'b0;
    case (req.cmd)
      CMD_ADD: for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] + b[i], clipped);
      CMD_SUB: for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] - b[i], clipped);
      CMD_SCALE:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(floor_frac(a[i] * s), clipped);
      CMD_DIVIDE: begin
        if (s == 0) zdiv = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = clamp_word((a[i] <<< FRAC) / s, clipped);
      end
      CMD_CROSS: begin
        // The differences of products need 65 bits, so go through 128-bit signed.
        r[0] = clamp_word(longint'((128'(signed'(a[1] * b[2])) - signed'(a[2] * b[1]))
                          >>> FRAC), clipped);
        r[1] = clamp_word(longint'((128'(signed'(a[2] * b[0])) - signed'(a[0] * b[2]))
                          >>> FRAC), clipped);
        r[2] = clamp_word(longint'((128'(signed'(a[0] * b[1])) - signed'(a[1] * b[0]))
                          >>> FRAC), clipped);
      end
      CMD_DOT: begin
        hi = 0;
        lo = 0;
        for (int i = 0; i < 3; i++) begin
          p = a[i] * b[i];
          h = floor_frac(p);
          hi += h;
          lo += p - (h <<< FRAC);
        end
        scalar = clamp_word(hi + floor_frac(lo), clipped);
      end
      default: begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
        len = root_floor(sq);
        if (req.cmd == CMD_NORMALIZE) begin
          if (len == 0) zdiv = 1'b1;
          else for (int i = 0; i < 3; i++)
            r[i] = clamp_word((a[i] <<< FRAC) / longint'(len), clipped);
        end else if (len > 64'd2147483647) begin
          clipped = 1'b1;
          scalar = MAX_S32;
        end else begin
          scalar = longint'(len);
        end
      end
    endcase
    res.words = {scalar[31:0], r[2][31:0], r[1][31:0], r[0][31:0]};
    res.flags = {clipped, zdiv};
    return res;
  endfunction

  // Operand word biased towards the interesting corners of the range.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'h0001_0000;
      4: return 32'(signed'($urandom_range(0, 262144)) - 131072);
      5, 6: return 32'(signed'($urandom_range(0, 65535 * 64)) - 65535 * 32);
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_request_t make_request(input cmd_e cmd, input logic [223:0] ops);
    vec_request_t req;
    req.cmd = cmd;
    req.operands = ops;
    return req;
  endfunction

  // Pick a gap: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stimulus: directed corner cases first, then random traffic.
  initial begin
    logic [223:0] ops;
    cmd_e cmd;
    for (int c = 0; c < 8; c++) begin
      cmd = cmd_e'(c);
      pending_requests.push_back(make_request(cmd, {7{32'h7FFF_FFFF}}));
      pending_requests.push_back(make_request(cmd, {7{32'h8000_0000}}));
    end
    // Division by zero, normalizing a zero and a tiny vector, the length of a zero vector, and sign corners.
    pending_requests.push_back(make_request(CMD_DIVIDE, {32'h0, {6{32'h0003_0000}}}));
    pending_requests.push_back(make_request(CMD_NORMALIZE, {{4{32'h1234_5678}}, 96'h0}));
    pending_requests.push_back(make_request(CMD_NORMALIZE, {{4{32'h0}}, 32'h0, 32'h0, 32'h1}));
    pending_requests.push_back(make_request(CMD_LENGTH, 224'h0));
    pending_requests.push_back(make_request(CMD_DIVIDE, {32'hFFFF_FFFF, {6{32'h8000_0000}}}));
    pending_requests.push_back(make_request(CMD_SCALE, {32'hFFFF_0000, {6{32'h8000_0000}}}));
    pending_requests.push_back(make_request(CMD_DOT, {{3{32'hFFFF_FFFF}}, {3{32'h0000_0001}}}));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      for (int w = 0; w < 7; w++) ops[32*w +: 32] = pick_word();
      // Keep some divisors zero so the flag turns up in the random part too.
      if ($urandom_range(15) == 0) ops[192 +: 32] = 32'h0;
      if ($urandom_range(15) == 0) ops[95:0] = 96'h0;
      pending_requests.push_back(make_request(cmd_e'($urandom_range(7)), ops));
      // Once, midway, let the unit drain completely before sending more.
      if (n == RANDOM_ITEMS / 2) begin
        wait (pending_requests.size() == 0);
        sender_hold = 1'b1;
        wait (!s_axis_tvalid && awaited_results.size() == 0);
        sender_hold = 1'b0;
      end
    end
    stimulus_done = 1'b1;
  end

  // Driver: presents the next queued request, with random gaps in between.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      send_gap <= 0;
    end else begin
      automatic bit busy = s_axis_tvalid && !s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(vector_outcome(make_request(cmd_e'(s_axis_tuser),
                                                              s_axis_tdata)));
      if (!busy) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0 && !sender_hold) begin
          automatic vec_request_t req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= req.operands;
          s_axis_tuser <= req.cmd;
          send_gap <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results with random stalls and checks them in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      take_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("unexpected result: data %h flags %b", m_axis_tdata, m_axis_tuser);
        end else begin
          automatic vec_result_t want = awaited_results.pop_front();
          if (want.words !== m_axis_tdata || want.flags !== m_axis_tuser) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("result mismatch: expected %h/%b actual %h/%b",
                       want.words, want.flags, m_axis_tdata, m_axis_tuser);
          end
        end
      end
      if (take_gap != 0) begin
        take_gap <= take_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) take_gap <= pick_gap();
      end
    end
  end

  // Watchdog: counts cycles in which neither stream completes a transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Reset once, then wait for the traffic to drain before judging the run.
  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        wait (stimulus_done && pending_requests.size() == 0 && !s_axis_tvalid
              && awaited_results.size() == 0);
        repeat (LATENCY + 20) @(posedge clk_i);
        if (mismatch_count == 0 && awaited_results.size() == 0)
          $display("end of test: clean");
        else
          $display("end of test: mismatches");
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("end of test: mismatches");
      end
    join_any
    $finish;
  end

endmodule

`default_nettype wire
